[hw/rtl/uart_rx_with_break_mode_core_macros.svh]
// assertion macros shared by the checker file
`ifndef UART_RX_WITH_BREAK_MODE_CORE_MACROS_SVH
`define UART_RX_WITH_BREAK_MODE_CORE_MACROS_SVH

// property checked outside reset
`define URXB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define URXB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/urxb_pkg.sv]
package urxb_pkg;

  // width of the sampling tick counter
  localparam int CNT_W = 16;
  // width of the bit period register
  localparam int PERIOD_W = 16;
  // width used to compare counter and sampling interval
  localparam int CMP_W = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
  // largest counter value, in compare width
  localparam logic [CMP_W-1:0] CMP_CNT_MAX = CMP_W'((64'd1 << CNT_W) - 64'd1);
  // smallest usable bit period
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(2);

  // frame bit positions
  localparam logic [3:0] BIT_START = 4'd0;
  localparam logic [3:0] BIT_STOP  = 4'd9;
  // low data bit count above which a low stop bit means a break
  localparam logic [3:0] LOW_BREAK_LIMIT = 4'd7;

  typedef logic [PERIOD_W-1:0] period_t;

  // one result of the receiver
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       test_mode;
  } urxb_result_t;

endpackage

[hw/rtl/urxb_channels.sv]
// sampled line level channel
interface urxb_in_if;
  logic valid;
  logic ready;
  logic line_level;
  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

// receiver result channel
interface urxb_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       test_mode;
  modport source (output valid, output byte_valid, output byte_data, output test_mode,
                  input ready);
  modport sink (input valid, input byte_valid, input byte_data, input test_mode,
                output ready);
endinterface

// bit period write channel
interface urxb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/uart_rx_with_break_mode_core.sv]
// 8N1 serial receiver with break-style test mode.
// in_ch carries one sampled line level per request; each request is one tick
// of the oversampling clock. out_ch returns exactly one result per request:
// byte_valid and byte_data when a frame closes with a high stop bit, and the
// test_mode flag after that tick. A low stop bit after eight low data bits
// enters test mode, which lasts until a high level is sampled at a bit time.
// cfg_ch writes bit_period (ticks per bit, values below 2 act as 2); write it
// only while the receiver is idle. cfg_ch is always ready.
// A result appears on out_ch in the cycle after its request is taken.
// Throughput: one request per cycle unless out_ch stalls; the output register
// lets a new request in while the previous result is taken in the same cycle.
// When out_ch stalls, the held result stays stable and in_ch.ready drops
// until it is taken, so no tick is lost.
// Reset (rst_n low, synchronous) clears the frame state, sets the previous
// line level high, empties the output register and sets bit_period to 16.
module uart_rx_with_break_mode_core (
  input logic clk,
  input logic rst_n,
  urxb_in_if.sink    in_ch,
  urxb_out_if.source out_ch,
  urxb_cfg_if.sink   cfg_ch
);
  import urxb_pkg::*;

  period_t      bit_period_r;
  logic         out_valid_r;
  urxb_result_t out_res_r;
  urxb_result_t res_nxt;
  logic         accept;

  // handshake: take a tick whenever the output slot is free or being emptied
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // bit period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_W'(16);
    end else if (cfg_ch.valid) begin
      bit_period_r <= cfg_ch.data;
    end
  end

  urxb_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .level      (in_ch.line_level),
    .bit_period (bit_period_r),
    .result     (res_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_valid = out_res_r.byte_valid;
  assign out_ch.byte_data  = out_res_r.byte_data;
  assign out_ch.test_mode  = out_res_r.test_mode;

endmodule

[hw/rtl/urxb_frame.sv]
module urxb_frame (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   level,
  input  urxb_pkg::period_t      bit_period,
  output urxb_pkg::urxb_result_t result
);
  import urxb_pkg::*;

  logic            prev_level_r, prev_level_nxt;
  logic            receiving_r, receiving_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [3:0]      bit_idx_r, bit_idx_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [3:0]      low_cnt_r, low_cnt_nxt;
  logic            test_r, test_nxt;

  period_t          period;
  period_t          interval;
  logic [CMP_W-1:0] limit;
  logic [CNT_W-1:0] tick_inc;
  logic             hit;
  logic [2:0]       data_pos;

  // interval: half period for start bit outside test mode, clamped to counter range
  always_comb begin
    period   = (bit_period < PERIOD_MIN) ? PERIOD_MIN : bit_period;
    interval = (bit_idx_r == BIT_START && !test_r) ? (period >> 1) : period;
    limit    = (CMP_W'(interval) > CMP_CNT_MAX) ? CMP_CNT_MAX : CMP_W'(interval);
    tick_inc = (tick_r != '1) ? tick_r + CNT_W'(1) : tick_r;
    hit      = (CMP_W'(tick_inc) >= limit);
    data_pos = 3'(bit_idx_r - 4'd1);
  end

  // frame state update for one tick
  always_comb begin
    receiving_nxt     = receiving_r;
    tick_nxt          = tick_r;
    bit_idx_nxt       = bit_idx_r;
    shift_nxt         = shift_r;
    low_cnt_nxt       = low_cnt_r;
    test_nxt          = test_r;
    result.byte_valid = 1'b0;
    result.byte_data  = 8'd0;
    if (!receiving_r) begin
      if (prev_level_r && !level) begin
        receiving_nxt = 1'b1;
        tick_nxt      = '0;
        bit_idx_nxt   = BIT_START;
        shift_nxt     = 8'd0;
        low_cnt_nxt   = 4'd0;
      end
    end else begin
      tick_nxt = tick_inc;
      if (hit) begin
        tick_nxt = '0;
        if (test_r) begin
          if (level) begin
            test_nxt      = 1'b0;
            receiving_nxt = 1'b0;
          end
        end else if (bit_idx_r == BIT_START) begin
          if (level) begin
            receiving_nxt = 1'b0;
          end else begin
            bit_idx_nxt = 4'd1;
          end
        end else if (bit_idx_r >= BIT_STOP) begin
          if (level) begin
            result.byte_valid = 1'b1;
            result.byte_data  = shift_r;
            receiving_nxt     = 1'b0;
          end else if (low_cnt_r > LOW_BREAK_LIMIT) begin
            test_nxt = 1'b1;
          end else begin
            receiving_nxt = 1'b0;
          end
          bit_idx_nxt = BIT_START;
          shift_nxt   = 8'd0;
          low_cnt_nxt = 4'd0;
        end else begin
          shift_nxt           = shift_r;
          shift_nxt[data_pos] = shift_r[data_pos] | level;
          bit_idx_nxt         = bit_idx_r + 4'd1;
          if (!level) begin
            low_cnt_nxt = low_cnt_r + 4'd1;
          end
        end
      end
    end
    prev_level_nxt   = level;
    result.test_mode = test_nxt;
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      receiving_r  <= 1'b0;
      tick_r       <= '0;
      bit_idx_r    <= BIT_START;
      shift_r      <= 8'd0;
      low_cnt_r    <= 4'd0;
      test_r       <= 1'b0;
    end else if (accept) begin
      prev_level_r <= prev_level_nxt;
      receiving_r  <= receiving_nxt;
      tick_r       <= tick_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      low_cnt_r    <= low_cnt_nxt;
      test_r       <= test_nxt;
    end
  end

endmodule

[hw/rtl/urxb_checker.sv]
`include "uart_rx_with_break_mode_core_macros.svh"

module urxb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_byte_valid,
  input logic [7:0] out_byte_data,
  input logic       out_test_mode
);

  // result slot is empty right after reset
  `URXB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result stays offered
  `URXB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")

  // a request taken always yields a result next cycle
  `URXB_ASSERT(a_req_result, in_valid && in_ready |=> out_valid, "request without result")

  // a delivered byte never coincides with test mode, and no byte means zero data
  `URXB_ASSERT(a_byte_clean,
    out_valid |-> (!(out_byte_valid && out_test_mode) &&
                   (out_byte_valid || out_byte_data == 8'd0)),
    "inconsistent result fields")

endmodule

bind uart_rx_with_break_mode_core urxb_checker u_urxb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte_valid (out_ch.byte_valid),
  .out_byte_data  (out_ch.byte_data),
  .out_test_mode  (out_ch.test_mode)
);

[test/tb_uart_rx_with_break_mode_core.sv]
`timescale 1ns / 1ps

module tb_uart_rx_with_break_mode_core;
  import urxb_pkg::*;

  localparam longint unsigned TICK_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam period_t PERIOD_AT_RESET = period_t'(16);
  localparam longint unsigned LIMIT_CYCLES = 64'd8_000_000;
  localparam urxb_result_t IDLE_RES = '{byte_valid: 1'b0, byte_data: 8'h00, test_mode: 1'b0};
  localparam urxb_result_t BREAK_RES = '{byte_valid: 1'b0, byte_data: 8'h00, test_mode: 1'b1};

  typedef enum logic {CHK_PRED, CHK_TYPED} chk_kind_e;
  typedef enum logic [2:0] {FR_GOOD, FR_BREAK, FR_BAD_STOP, FR_GLITCH, FR_NOISE} frame_kind_e;

  typedef struct {
    logic        lvl;
    chk_kind_e   how;
    urxb_result_t want;
  } drill_row_t;

  // receiver state as seen from outside
  typedef struct {
    logic           prev;
    logic           busy;
    logic [CNT_W-1:0] ticks;
    logic [3:0]     idx;
    logic [7:0]     shreg;
    logic [3:0]     zeros;
    logic           brk;
  } rx_state_t;

  logic clk;
  logic rst_n;

  urxb_in_if  in_if();
  urxb_out_if out_if();
  urxb_cfg_if cfg_if();

  uart_rx_with_break_mode_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  rx_state_t    rx;
  period_t      period_reg;
  urxb_result_t rx_result_q[$];
  drill_row_t   drill_rows [26];
  int unsigned  mismatch_count;
  int unsigned  sent_count;
  int unsigned  result_count;
  longint unsigned cycle_count;
  bit           in_offer;
  bit           sender_burst;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
             $time, what, result_count, got, want);
    mismatch_count++;
  endtask

  // expected receiver output for one tick, advances the local state
  function automatic urxb_result_t rx_predict(input logic lvl);
    urxb_result_t res;
    longint unsigned per;
    longint unsigned lim;
    res = IDLE_RES;
    if (!rx.busy) begin
      if (rx.prev && !lvl) begin
        rx.busy  = 1'b1;
        rx.ticks = '0;
        rx.idx   = BIT_START;
        rx.shreg = '0;
        rx.zeros = '0;
      end
    end else begin
      per = 64'((period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg);
      lim = (rx.idx == BIT_START && !rx.brk) ? (per >> 1) : per;
      if (lim > TICK_MAX) lim = TICK_MAX;
      if (64'(rx.ticks) < TICK_MAX) rx.ticks++;
      if (64'(rx.ticks) >= lim) begin
        rx.ticks = '0;
        if (rx.brk) begin
          // test mode ends on the first high sample at a bit time
          if (lvl) begin
            rx.brk  = 1'b0;
            rx.busy = 1'b0;
          end
        end else if (rx.idx == BIT_START) begin
          if (lvl) rx.busy = 1'b0;
          else rx.idx = BIT_START + 4'd1;
        end else if (rx.idx >= BIT_STOP) begin
          if (lvl) begin
            res.byte_valid = 1'b1;
            res.byte_data  = rx.shreg;
            rx.busy        = 1'b0;
          end else if (rx.zeros > LOW_BREAK_LIMIT) begin
            rx.brk = 1'b1;
          end else begin
            rx.busy = 1'b0;
          end
          rx.idx   = BIT_START;
          rx.shreg = '0;
          rx.zeros = '0;
        end else begin
          // data bits arrive lsb first
          rx.shreg = rx.shreg | (8'(lvl) << (rx.idx - 4'd1));
          rx.idx++;
          if (!lvl) rx.zeros++;
        end
      end
    end
    rx.prev = lvl;
    res.test_mode = rx.brk;
    return res;
  endfunction

  // offer one tick after a random gap, predict once it is taken
  task automatic send_tick(input logic lvl, input chk_kind_e how = CHK_PRED,
                           input urxb_result_t want = IDLE_RES);
    int unsigned gap;
    int unsigned r;
    urxb_result_t pred;
    r = $urandom_range(0, 99);
    if (sender_burst || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      if (in_offer) in_if.valid <= 1'b0;
      in_offer = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.line_level <= lvl;
    in_offer = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = rx_predict(lvl);
    rx_result_q.push_back((how == CHK_TYPED) ? want : pred);
    sent_count++;
  endtask

  task automatic send_level(input logic lvl, input int unsigned n);
    repeat (n) send_tick(lvl);
  endtask

  // stop offering and wait until every expected result is back
  task automatic drain_results();
    if (in_offer) in_if.valid <= 1'b0;
    in_offer = 1'b0;
    while (rx_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_bit_period(input period_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    period_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  // one serial frame of the given shape at bp ticks per bit
  task automatic send_frame(input int unsigned bp, input frame_kind_e kind);
    logic [7:0] val;
    int unsigned b;
    case ($urandom_range(0, 3))
      0: val = 8'h00;
      1: val = 8'hFF;
      default: val = 8'($urandom);
    endcase
    if (kind == FR_BREAK) val = 8'h00;
    send_level(1'b1, $urandom_range(1, 2 * bp));
    case (kind)
      FR_GLITCH: begin
        send_level(1'b0, $urandom_range(1, bp));
        send_level(1'b1, bp);
      end
      FR_NOISE: begin
        repeat ($urandom_range(4, 24)) send_tick(1'($urandom));
      end
      default: begin
        send_level(1'b0, bp);
        for (b = 0; b < 8; b++) send_level(val[b], bp);
        if (kind == FR_GOOD) begin
          send_level(1'b1, bp);
        end else begin
          // low stop bit, a break holds the line low a while longer
          send_level(1'b0, bp);
          if (kind == FR_BREAK) send_level(1'b0, $urandom_range(0, 3 * bp));
          send_level(1'b1, bp);
        end
      end
    endcase
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned r;
    bit calm;
    bit long_hold_done;
    hold_left = 0;
    calm = 1'b0;
    long_hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_hold_done && result_count >= 500) begin
        out_if.ready <= 1'b0;
        hold_left = 300;
        long_hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) calm = !calm;
        r = $urandom_range(0, 99);
        if (calm || r < 75) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        end
      end
    end
  end

  // result checker
  initial begin
    urxb_result_t want;
    result_count = 0;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (rx_result_q.size() == 0) begin
          report_mismatch("result with nothing expected",
                          32'({out_if.byte_valid, out_if.byte_data, out_if.test_mode}), 0);
        end else begin
          want = rx_result_q.pop_front();
          if (out_if.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(out_if.byte_valid), 32'(want.byte_valid));
          if (out_if.byte_data !== want.byte_data)
            report_mismatch("byte_data", 32'(out_if.byte_data), 32'(want.byte_data));
          if (out_if.test_mode !== want.test_mode)
            report_mismatch("test_mode", 32'(out_if.test_mode), 32'(want.test_mode));
        end
        result_count++;
      end
    end
  end

  // stimulus
  initial begin
    period_t rand_periods [6];
    int unsigned goal;
    int unsigned eff;
    int unsigned r;
    frame_kind_e kind;

    in_if.valid = 1'b0;
    in_if.line_level = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_offer = 1'b0;
    sender_burst = 1'b0;
    sent_count = 0;
    rand_periods = '{period_t'(1), period_t'(3), period_t'(2), period_t'(5),
                     period_t'(4), period_t'(7)};

    // break frame at the shortest period: glitch start, all-low byte, low stop
    drill_rows = '{
      0:  '{1'b1, CHK_TYPED, IDLE_RES},
      2:  '{1'b1, CHK_TYPED, IDLE_RES},
      3:  '{1'b1, CHK_PRED,  IDLE_RES},
      23: '{1'b0, CHK_TYPED, BREAK_RES},
      24: '{1'b1, CHK_TYPED, BREAK_RES},
      25: '{1'b1, CHK_TYPED, IDLE_RES},
      default: '{1'b0, CHK_PRED, IDLE_RES}
    };

    rx = '{prev: 1'b1, busy: 1'b0, ticks: '0, idx: BIT_START, shreg: 8'h00,
           zeros: 4'd0, brk: 1'b0};
    period_reg = PERIOD_AT_RESET;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // one clean frame at the reset bit period
    send_frame(32'(PERIOD_AT_RESET), FR_GOOD);
    drain_results();

    // zero acts as the minimum period
    write_bit_period('0);
    foreach (drill_rows[i])
      send_tick(drill_rows[i].lvl, drill_rows[i].how, drill_rows[i].want);

    // random frames over several short periods
    foreach (rand_periods[p]) begin
      drain_results();
      write_bit_period(rand_periods[p]);
      eff = 32'((period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg);
      goal = sent_count + 150;
      while (sent_count < goal) begin
        sender_burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 29) == 0) drain_results();
        r = $urandom_range(0, 99);
        if (r < 55) kind = FR_GOOD;
        else if (r < 68) kind = FR_BREAK;
        else if (r < 80) kind = FR_BAD_STOP;
        else if (r < 92) kind = FR_GLITCH;
        else kind = FR_NOISE;
        send_frame(eff, kind);
      end
    end

    // longest period: edge, then a high line well before the half-bit sample
    drain_results();
    write_bit_period('1);
    sender_burst = 1'b1;
    send_tick(1'b1);
    send_tick(1'b0);
    send_level(1'b1, 60);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
